// ===== rtl/gtcb_pkg.sv =====
// ----------------------------------------------------------------------------
// gtcb_pkg
// shared types, field widths, mode word layout and operation codes for the
// gated timer counter bank
// ----------------------------------------------------------------------------
package gtcb_pkg;

    // bank shape
    localparam int NUM_TIMERS  = 4;
    localparam int HOLD_TIMERS = 2;
    localparam int COUNT_BITS  = 16;
    localparam int HBLANK_STEP = 1;

    // beat field widths
    localparam int OP_BITS    = 3;
    localparam int IDX_BITS   = 2;
    localparam int SEL_BITS   = 2;
    localparam int DATA_BITS  = 16;
    localparam int IRQ_BITS   = 4;
    localparam int MODE_BITS  = 12;
    localparam int PHASE_BITS = 9;

    localparam int IN_BITS    = OP_BITS + IDX_BITS + SEL_BITS + DATA_BITS;
    localparam int IN_BYTES   = (IN_BITS + 7) / 8;
    localparam int OUT_BITS   = DATA_BITS + IRQ_BITS;
    localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;

    // mode word layout
    localparam int MB_CLK_LO    = 0;
    localparam int MB_CLK_HI    = 1;
    localparam int MB_GATE_EN   = 2;
    localparam int MB_GATE_SRC  = 3;
    localparam int MB_GMODE_LO  = 4;
    localparam int MB_GMODE_HI  = 5;
    localparam int MB_ZERO_RET  = 6;
    localparam int MB_COUNTING  = 7;
    localparam int MB_TGT_IRQ   = 8;
    localparam int MB_OVF_IRQ   = 9;
    localparam int MB_TGT_FLAG  = 10;
    localparam int MB_OVF_FLAG  = 11;

    localparam logic [MODE_BITS-1:0] MODE_FLAGS = 12'hc00;
    localparam logic [MODE_BITS-1:0] MODE_CTRL  = 12'h3ff;

    // clock sources
    localparam logic [1:0] CLK_DIV2   = 2'd0;
    localparam logic [1:0] CLK_DIV32  = 2'd1;
    localparam logic [1:0] CLK_HBLANK = 2'd3;

    // prescaler rates
    localparam logic [PHASE_BITS:0] RATE_DIV2   = (PHASE_BITS+1)'(2);
    localparam logic [PHASE_BITS:0] RATE_DIV32  = (PHASE_BITS+1)'(32);
    localparam logic [PHASE_BITS:0] RATE_DIV512 = (PHASE_BITS+1)'(512);

    // gate modes
    localparam logic [1:0] GM_PAUSE = 2'd0;
    localparam logic [1:0] GM_START = 2'd1;
    localparam logic [1:0] GM_END   = 2'd2;
    localparam logic [1:0] GM_BOTH  = 2'd3;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_READ      = 3'd2,
        OP_HBL_START = 3'd3,
        OP_HBL_END   = 3'd4,
        OP_VBL_START = 3'd5,
        OP_VBL_END   = 3'd6,
        OP_NONE      = 3'd7
    } t_op;

    typedef enum logic [SEL_BITS-1:0] {
        REG_COUNT  = 2'd0,
        REG_MODE   = 2'd1,
        REG_TARGET = 2'd2,
        REG_HOLD   = 2'd3
    } t_reg_sel;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [MODE_BITS-1:0]  t_mode;

    // command broadcast to every timer for one beat
    typedef struct packed {
        logic                 en;
        t_op                  op;
        t_reg_sel             sel;
        logic [DATA_BITS-1:0] data;
    } t_timer_cmd;

    // per-timer view back to the top level
    typedef struct packed {
        t_count count;
        t_mode  mode;
        t_count target;
        logic   irq;
    } t_timer_stat;

endpackage

// ===== rtl/gtcb_timer.sv =====
// ----------------------------------------------------------------------------
// gtcb_timer
// one timer: count, target, mode, prescaler phase and compare disarm, with
// its single-pass next-state logic for tick, write and sync beats
// ----------------------------------------------------------------------------
module gtcb_timer
    import gtcb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_timer_cmd  i_cmd,
    input  logic        i_wr_sel,
    output t_timer_stat o_stat
);

    typedef struct packed {
        t_count count;
        t_mode  mode;
        logic   dis;
        logic   irq;
    } t_evt;

    t_count                r_count;
    t_count                r_target;
    t_mode                 r_mode;
    logic                  r_dis;
    logic [PHASE_BITS-1:0] r_phase;

    t_count                n_count;
    t_count                n_target;
    t_mode                 n_mode;
    logic                  n_dis;
    logic [PHASE_BITS-1:0] n_phase;

    logic                  irq;
    t_evt                  evt;
    logic [1:0]            clk_src;
    logic [PHASE_BITS:0]   rate;
    logic [PHASE_BITS:0]   phase_inc;
    logic [COUNT_BITS:0]   tick_cnt;
    logic                  is_vblank;
    t_count                wr_val;
    t_mode                 wr_mode;

    function automatic logic is_gated(input t_mode m);
        logic r;
        r = m[MB_GATE_EN] && !(!m[MB_GATE_SRC] && (m[MB_CLK_HI:MB_CLK_LO] == CLK_HBLANK));
        return r;
    endfunction

    // target test then overflow test
    function automatic t_evt test_events(input logic [COUNT_BITS:0] cnt,
                                         input t_count tgt, input logic dis,
                                         input t_mode m);
        t_evt                r;
        logic [COUNT_BITS:0] c;
        r.mode = m;
        r.dis  = dis;
        r.irq  = 1'b0;
        c      = cnt;
        if (!dis && (cnt >= {1'b0, tgt})) begin
            if (m[MB_TGT_IRQ] && !m[MB_TGT_FLAG]) begin
                r.mode[MB_TGT_FLAG] = 1'b1;
                r.irq               = 1'b1;
            end
            if (m[MB_ZERO_RET]) begin
                c = cnt - {1'b0, tgt};
            end else begin
                r.dis = 1'b1;
            end
        end
        if (c[COUNT_BITS]) begin
            if (m[MB_OVF_IRQ] && !m[MB_OVF_FLAG]) begin
                r.mode[MB_OVF_FLAG] = 1'b1;
                r.irq               = 1'b1;
            end
            c[COUNT_BITS] = 1'b0;
            r.dis         = 1'b0;
        end
        r.count = c[COUNT_BITS-1:0];
        return r;
    endfunction

    assign clk_src   = r_mode[MB_CLK_HI:MB_CLK_LO];
    assign phase_inc = {1'b0, r_phase} + (PHASE_BITS+1)'(1);
    assign is_vblank = (i_cmd.op == OP_VBL_START) || (i_cmd.op == OP_VBL_END);
    assign wr_val    = COUNT_BITS'(i_cmd.data);
    assign wr_mode   = (r_mode & MODE_FLAGS & ~i_cmd.data[MODE_BITS-1:0])
                     | (i_cmd.data[MODE_BITS-1:0] & MODE_CTRL);

    always_comb begin
        case (clk_src)
            CLK_DIV2:  rate = RATE_DIV2;
            CLK_DIV32: rate = RATE_DIV32;
            default:   rate = RATE_DIV512;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_target = r_target;
        n_mode   = r_mode;
        n_dis    = r_dis;
        n_phase  = r_phase;
        irq      = 1'b0;
        tick_cnt = {1'b0, r_count};
        evt      = '0;
        case (i_cmd.op)
            OP_TICK: begin
                if (r_mode[MB_COUNTING] && (clk_src != CLK_HBLANK)) begin
                    if (phase_inc >= rate) begin
                        n_phase  = '0;
                        tick_cnt = {1'b0, r_count} + (COUNT_BITS+1)'(1);
                    end else begin
                        n_phase  = phase_inc[PHASE_BITS-1:0];
                    end
                    evt     = test_events(tick_cnt, r_target, r_dis, r_mode);
                    n_count = evt.count;
                    n_mode  = evt.mode;
                    n_dis   = evt.dis;
                    irq     = evt.irq;
                end
            end
            OP_HBL_START, OP_VBL_START: begin
                // on hblank start, hblank-clocked timers step first, then the gate acts
                if (!is_vblank && r_mode[MB_COUNTING] && (clk_src == CLK_HBLANK)) begin
                    evt     = test_events({1'b0, r_count} + (COUNT_BITS+1)'(HBLANK_STEP),
                                          r_target, r_dis, r_mode);
                    n_count = evt.count;
                    n_mode  = evt.mode;
                    n_dis   = evt.dis;
                    irq     = evt.irq;
                end
                if (is_gated(n_mode) && (n_mode[MB_GATE_SRC] == is_vblank)) begin
                    case (n_mode[MB_GMODE_HI:MB_GMODE_LO])
                        GM_PAUSE: begin
                            n_mode[MB_COUNTING] = 1'b0;
                            n_phase             = '0;
                        end
                        GM_START, GM_BOTH: begin
                            n_mode[MB_COUNTING] = 1'b1;
                            n_count             = '0;
                            n_dis               = 1'b0;
                            n_phase             = '0;
                        end
                        default: ;
                    endcase
                end
            end
            OP_HBL_END, OP_VBL_END: begin
                if (is_gated(r_mode) && (r_mode[MB_GATE_SRC] == is_vblank)) begin
                    case (r_mode[MB_GMODE_HI:MB_GMODE_LO])
                        GM_PAUSE: begin
                            n_mode[MB_COUNTING] = 1'b1;
                            n_phase             = '0;
                        end
                        GM_END, GM_BOTH: begin
                            n_mode[MB_COUNTING] = 1'b1;
                            n_count             = '0;
                            n_dis               = 1'b0;
                            n_phase             = '0;
                        end
                        default: ;
                    endcase
                end
            end
            OP_WRITE: begin
                if (i_wr_sel) begin
                    case (i_cmd.sel)
                        REG_COUNT: begin
                            n_count = wr_val;
                            n_dis   = wr_val > r_target;
                            if (!r_mode[MB_COUNTING]) begin
                                n_phase = '0;
                            end
                        end
                        REG_MODE: begin
                            if (!r_mode[MB_COUNTING]) begin
                                n_phase = '0;
                            end
                            n_mode = wr_mode;
                            if (is_gated(wr_mode)) begin
                                n_mode[MB_COUNTING] = 1'b0;
                                n_count             = '0;
                                n_phase             = '0;
                            end
                        end
                        REG_TARGET: begin
                            n_target = wr_val;
                            n_dis    = wr_val <= r_count;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_target <= '1;
            r_mode   <= '0;
            r_dis    <= 1'b0;
            r_phase  <= '0;
        end else if (i_cmd.en) begin
            r_count  <= n_count;
            r_target <= n_target;
            r_mode   <= n_mode;
            r_dis    <= n_dis;
            r_phase  <= n_phase;
        end
    end

    assign o_stat.count  = r_count;
    assign o_stat.mode   = r_mode;
    assign o_stat.target = r_target;
    assign o_stat.irq    = i_cmd.en && irq;

endmodule

// ===== rtl/gtcb_out_skid.sv =====
// ----------------------------------------------------------------------------
// gtcb_out_skid
// result register with a skid stage behind it, so a new result can be
// stored while the one in front still waits for the sink
// ----------------------------------------------------------------------------
module gtcb_out_skid
    import gtcb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [OUT_BYTES*8-1:0] i_data,
    output logic                   o_room,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_BYTES*8-1:0] o_m_axis_tdata
);

    logic                   r_out_valid;
    logic                   r_skid_valid;
    logic [OUT_BYTES*8-1:0] r_out_data;
    logic [OUT_BYTES*8-1:0] r_skid_data;
    logic                   take;

    assign take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_data;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data  <= i_data;
            end
        end
    end

    assign o_room          = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/gated_timer_counter_bank.sv =====
// ----------------------------------------------------------------------------
// gated_timer_counter_bank
// four gated 16-bit timers with prescalers, target compare, overflow wrap,
// sticky interrupt flags and hold registers on timers 0 and 1
// ----------------------------------------------------------------------------
// a taken input beat sits in the input register, then the timer update
// writes its result into the result register in one pass
// throughput: one beat per cycle, set by the one-pass timer update;
// the input side stalls only while both result register and skid are full
// reset: synchronous, active low; counts, modes, phases and holds clear,
// targets go to all ones, no beat is held on either side
// ----------------------------------------------------------------------------
module gated_timer_counter_bank
    import gtcb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // operation[2:0], counter_index[4:3], register_select[6:5],
    // write_data[22:7], zero pad[23]
    input  logic [IN_BYTES*8-1:0]  i_s_axis_tdata,
    // master side
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // read_data[15:0], irq_raised[19:16], zero pad[23:20]
    output logic [OUT_BYTES*8-1:0] o_m_axis_tdata
);

    // input register
    logic                 r_in_valid;
    t_op                  r_op;
    logic [IDX_BITS-1:0]  r_idx;
    t_reg_sel             r_sel;
    logic [DATA_BITS-1:0] r_data;

    logic [DATA_BITS-1:0] r_hold [HOLD_TIMERS];

    logic                   room;
    logic                   advance;
    logic                   in_take;
    t_timer_cmd             cmd;
    t_timer_stat            stat [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  wr_sel;
    logic [DATA_BITS-1:0]   rd_data;
    logic [IRQ_BITS-1:0]    irq;
    logic [OUT_BYTES*8-1:0] res_data;

    // the input register moves on whenever the skid stage has space
    assign advance         = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || room;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= t_op'(i_s_axis_tdata[OP_BITS-1:0]);
            r_idx  <= i_s_axis_tdata[OP_BITS +: IDX_BITS];
            r_sel  <= t_reg_sel'(i_s_axis_tdata[OP_BITS+IDX_BITS +: SEL_BITS]);
            r_data <= i_s_axis_tdata[OP_BITS+IDX_BITS+SEL_BITS +: DATA_BITS];
        end
    end

    // one command to every timer, the write strobe picks the addressed one
    assign cmd.en   = advance;
    assign cmd.op   = r_op;
    assign cmd.sel  = r_sel;
    assign cmd.data = r_data;

    for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
        assign wr_sel[t] = (r_op == OP_WRITE) && (int'(r_idx) == t);

        gtcb_timer u_timer (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd),
            .i_wr_sel (wr_sel[t]),
            .o_stat   (stat[t])
        );
    end

    // hold registers only exist for the low timers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < HOLD_TIMERS; h++) begin
                r_hold[h] <= '0;
            end
        end else if (advance && (r_op == OP_WRITE) && (r_sel == REG_HOLD)) begin
            for (int h = 0; h < HOLD_TIMERS; h++) begin
                if (int'(r_idx) == h) begin
                    r_hold[h] <= r_data;
                end
            end
        end
    end

    // read mux: zero on anything but a read, or on an absent register
    always_comb begin
        rd_data = '0;
        if (r_op == OP_READ) begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
                if (int'(r_idx) == t) begin
                    case (r_sel)
                        REG_COUNT:  rd_data = DATA_BITS'(stat[t].count);
                        REG_MODE:   rd_data = DATA_BITS'(stat[t].mode);
                        REG_TARGET: rd_data = DATA_BITS'(stat[t].target);
                        default:    rd_data = '0;
                    endcase
                end
            end
            if (r_sel == REG_HOLD) begin
                for (int h = 0; h < HOLD_TIMERS; h++) begin
                    if (int'(r_idx) == h) begin
                        rd_data = r_hold[h];
                    end
                end
            end
        end
    end

    // interrupt lines exist for the first four timers only
    always_comb begin
        irq = '0;
        for (int t = 0; t < NUM_TIMERS; t++) begin
            if (t < IRQ_BITS) begin
                irq[t] = stat[t].irq;
            end
        end
    end

    assign res_data = {(OUT_BYTES*8-OUT_BITS)'(0), irq, rd_data};

    gtcb_out_skid u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (advance),
        .i_data          (res_data),
        .o_room          (room),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for gated_timer_counter_bank: timer operations are
// streamed in and every result beat is checked against a behavioural copy of
// the four-timer bank that runs alongside, with random idling on both sides
// ----------------------------------------------------------------------------
module testbench;
    import gtcb_pkg::*;

    // watchdog: cycles with no beat moved on either side before giving up
    localparam int STALL_LIMIT  = 400;
    // cycles to let the pipeline settle after the last expected result
    localparam int DRAIN_CYCLES = 16;

    // single mode bits, for building mode words by name
    localparam logic [15:0] M_GATE  = 16'(1) << MB_GATE_EN;
    localparam logic [15:0] M_VSRC  = 16'(1) << MB_GATE_SRC;
    localparam logic [15:0] M_ZRET  = 16'(1) << MB_ZERO_RET;
    localparam logic [15:0] M_COUNT = 16'(1) << MB_COUNTING;
    localparam logic [15:0] M_TIRQ  = 16'(1) << MB_TGT_IRQ;
    localparam logic [15:0] M_OIRQ  = 16'(1) << MB_OVF_IRQ;
    localparam logic [15:0] M_TFLAG = 16'(1) << MB_TGT_FLAG;
    localparam logic [15:0] M_OFLAG = 16'(1) << MB_OVF_FLAG;

    typedef struct {
        logic [DATA_BITS-1:0] read_data;
        logic [IRQ_BITS-1:0]  irq_raised;
    } t_timer_reply;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    wire                    s_tready;
    // operation[2:0], counter_index[4:3], register_select[6:5],
    // write_data[22:7], zero pad[23]
    logic [IN_BYTES*8-1:0]  s_tdata;
    wire                    m_tvalid;
    logic                   m_tready;
    // read_data[15:0], irq_raised[19:16], zero pad[23:20]
    wire  [OUT_BYTES*8-1:0] m_tdata;

    // idling on either side is switched off for the last stretch of the run
    bit idling_on = 1'b1;
    int fail_count = 0;

    // replies predicted for beats already sent, oldest first
    t_timer_reply awaited_replies[$];

    // sync phase as seen by the stimulus, to keep start/end pairs well formed
    bit in_hblank = 1'b0;
    bit in_vblank = 1'b0;

    gated_timer_counter_bank DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // behavioural copy of the timer bank, starting from its reset state
    // ------------------------------------------------------------------------
    t_count                count_reg  [NUM_TIMERS] = '{default: '0};
    t_count                target_reg [NUM_TIMERS] = '{default: '1};
    logic                  disarm_reg [NUM_TIMERS] = '{default: 1'b0};
    t_mode                 mode_reg   [NUM_TIMERS] = '{default: '0};
    logic [PHASE_BITS-1:0] phase_reg  [NUM_TIMERS] = '{default: '0};
    logic [DATA_BITS-1:0]  hold_reg   [HOLD_TIMERS] = '{default: '0};

    function automatic int prescale_rate(t_mode m);
        case (m[MB_CLK_HI:MB_CLK_LO])
            CLK_DIV2:  return 2;
            CLK_DIV32: return 32;
            default:   return 512;
        endcase
    endfunction

    // gate enable counts unless an hblank gate meets an hblank clock
    function automatic logic timer_gated(t_mode m);
        return m[MB_GATE_EN] &&
               !(!m[MB_GATE_SRC] && m[MB_CLK_HI:MB_CLK_LO] == CLK_HBLANK);
    endfunction

    // target test, then overflow test; cnt may sit one past the count range
    function automatic logic check_events(int i, logic [COUNT_BITS:0] cnt);
        logic hit;
        hit = 1'b0;
        if (!disarm_reg[i] && cnt >= {1'b0, target_reg[i]}) begin
            if (mode_reg[i][MB_TGT_IRQ] && !mode_reg[i][MB_TGT_FLAG]) begin
                mode_reg[i][MB_TGT_FLAG] = 1'b1;
                hit = 1'b1;
            end
            if (mode_reg[i][MB_ZERO_RET])
                cnt = cnt - {1'b0, target_reg[i]};
            else
                disarm_reg[i] = 1'b1;
        end
        if (cnt[COUNT_BITS]) begin
            if (mode_reg[i][MB_OVF_IRQ] && !mode_reg[i][MB_OVF_FLAG]) begin
                mode_reg[i][MB_OVF_FLAG] = 1'b1;
                hit = 1'b1;
            end
            cnt[COUNT_BITS] = 1'b0;
            disarm_reg[i] = 1'b0;
        end
        count_reg[i] = cnt[COUNT_BITS-1:0];
        return hit;
    endfunction

    function automatic void restart_timer(int i);
        mode_reg[i][MB_COUNTING] = 1'b1;
        count_reg[i]  = '0;
        disarm_reg[i] = 1'b0;
        phase_reg[i]  = '0;
    endfunction

    function automatic logic [IRQ_BITS-1:0] sync_start(logic vb);
        logic [IRQ_BITS-1:0] irq;
        irq = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            // hblank-clocked timers step before their gate is looked at
            if (!vb && mode_reg[i][MB_COUNTING] &&
                mode_reg[i][MB_CLK_HI:MB_CLK_LO] == CLK_HBLANK)
                irq[i] = check_events(i, {1'b0, count_reg[i]}
                                         + (COUNT_BITS+1)'(HBLANK_STEP));
            if (!timer_gated(mode_reg[i]) || mode_reg[i][MB_GATE_SRC] != vb)
                continue;
            case (mode_reg[i][MB_GMODE_HI:MB_GMODE_LO])
                GM_PAUSE: begin
                    mode_reg[i][MB_COUNTING] = 1'b0;
                    phase_reg[i] = '0;
                end
                GM_START, GM_BOTH: restart_timer(i);
                default: ;
            endcase
        end
        return irq;
    endfunction

    function automatic void sync_end(logic vb);
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!timer_gated(mode_reg[i]) || mode_reg[i][MB_GATE_SRC] != vb)
                continue;
            case (mode_reg[i][MB_GMODE_HI:MB_GMODE_LO])
                GM_PAUSE: begin
                    mode_reg[i][MB_COUNTING] = 1'b1;
                    phase_reg[i] = '0;
                end
                GM_END, GM_BOTH: restart_timer(i);
                default: ;
            endcase
        end
    endfunction

    function automatic void write_register(int i, t_reg_sel sel, logic [15:0] data);
        t_mode m;
        case (sel)
            REG_COUNT: begin
                count_reg[i]  = data;
                disarm_reg[i] = data > target_reg[i];
                if (!mode_reg[i][MB_COUNTING]) phase_reg[i] = '0;
            end
            REG_MODE: begin
                m = mode_reg[i];
                if (!m[MB_COUNTING]) phase_reg[i] = '0;
                // flags clear by writing one, control bits load directly
                m = m & ~(data[MODE_BITS-1:0] & MODE_FLAGS);
                m = (m & MODE_FLAGS) | (data[MODE_BITS-1:0] & MODE_CTRL);
                if (timer_gated(m)) begin
                    m[MB_COUNTING] = 1'b0;
                    count_reg[i]   = '0;
                    phase_reg[i]   = '0;
                end
                mode_reg[i] = m;
            end
            REG_TARGET: begin
                target_reg[i] = data;
                disarm_reg[i] = data <= count_reg[i];
            end
            default: begin
                if (i < HOLD_TIMERS) hold_reg[i] = data;
            end
        endcase
    endfunction

    // one beat through the bank: updates the copy and returns the reply
    function automatic void timer_bank_step(input t_op op, input logic [1:0] idx,
                                            input t_reg_sel sel,
                                            input logic [15:0] data,
                                            output t_timer_reply r);
        logic [COUNT_BITS:0] cnt;
        r.read_data  = '0;
        r.irq_raised = '0;
        case (op)
            OP_TICK: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (!mode_reg[i][MB_COUNTING] ||
                        mode_reg[i][MB_CLK_HI:MB_CLK_LO] == CLK_HBLANK)
                        continue;
                    cnt = {1'b0, count_reg[i]};
                    if (int'(phase_reg[i]) + 1 >= prescale_rate(mode_reg[i])) begin
                        phase_reg[i] = '0;
                        cnt = cnt + 1'b1;
                    end else begin
                        phase_reg[i] = phase_reg[i] + 1'b1;
                    end
                    r.irq_raised[i] = check_events(i, cnt);
                end
            end
            OP_WRITE: write_register(idx, sel, data);
            OP_READ: begin
                case (sel)
                    REG_COUNT:  r.read_data = count_reg[idx];
                    REG_MODE:   r.read_data = 16'(mode_reg[idx]);
                    REG_TARGET: r.read_data = target_reg[idx];
                    default:    r.read_data = (idx < HOLD_TIMERS) ? hold_reg[idx] : '0;
                endcase
            end
            OP_HBL_START: r.irq_raised = sync_start(1'b0);
            OP_HBL_END:   sync_end(1'b0);
            OP_VBL_START: r.irq_raised = sync_start(1'b1);
            OP_VBL_END:   sync_end(1'b1);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [15:0] mode_value(logic [1:0] clk_src,
                                               logic [1:0] gate_mode,
                                               logic [15:0] bits);
        logic [15:0] v;
        v = bits;
        v[MB_CLK_HI:MB_CLK_LO]     = clk_src;
        v[MB_GMODE_HI:MB_GMODE_LO] = gate_mode;
        return v;
    endfunction

    // send one beat; the valid stays up between back-to-back beats
    task automatic send_beat(t_op op, logic [1:0] idx, t_reg_sel sel, logic [15:0] data);
        t_timer_reply r;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        timer_bank_step(op, idx, sel, data, r);
        awaited_replies.push_back(r);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, data, sel, idx, op};
        do @(posedge clk); while (!s_tready);
    endtask

    // write data steered towards targets and overflow, or a varied mode word
    function automatic logic [15:0] pick_write_data(logic [1:0] idx, t_reg_sel sel,
                                                    bit sync_heavy);
        logic [15:0] v;
        int          clk_pick;
        v = 16'($urandom);
        case (sel)
            REG_COUNT: begin
                case ($urandom_range(0, 3))
                    0: v = target_reg[idx] - 16'($urandom_range(0, 6));
                    1: v = 16'hffff - 16'($urandom_range(0, 6));
                    default: ;
                endcase
            end
            REG_TARGET: begin
                if ($urandom_range(0, 2) != 0)
                    v = count_reg[idx] + 16'($urandom_range(0, 12));
            end
            REG_MODE: begin
                // mostly the fast prescaler so compares and wraps come often
                clk_pick = $urandom_range(0, 9);
                if (sync_heavy && clk_pick >= 7)
                    v[MB_CLK_HI:MB_CLK_LO] = CLK_HBLANK;
                else if (clk_pick < 6)
                    v[MB_CLK_HI:MB_CLK_LO] = CLK_DIV2;
                else if (clk_pick < 8)
                    v[MB_CLK_HI:MB_CLK_LO] = CLK_DIV32;
                v[MB_GATE_EN]  = sync_heavy ? $urandom_range(0, 1) == 0
                                            : $urandom_range(0, 3) == 0;
                v[MB_COUNTING] = $urandom_range(0, 3) != 0;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_random_beat(bit sync_heavy);
        int          pick;
        t_op         op;
        logic [1:0]  idx;
        t_reg_sel    sel;
        logic [15:0] data;
        pick = $urandom_range(0, 99);
        idx  = 2'($urandom_range(0, 3));
        sel  = t_reg_sel'($urandom_range(0, 3));
        data = 16'($urandom);
        if (pick < (sync_heavy ? 35 : 45)) begin
            op = OP_TICK;
        end else if (pick < (sync_heavy ? 55 : 65)) begin
            op   = OP_WRITE;
            data = pick_write_data(idx, sel, sync_heavy);
        end else if (pick < (sync_heavy ? 65 : 77)) begin
            op = OP_READ;
        end else if (pick < 97) begin
            if ($urandom_range(0, 9) == 0) begin
                // out-of-order sync event
                op = t_op'($urandom_range(OP_HBL_START, OP_VBL_END));
            end else if ($urandom_range(0, 3) != 0) begin
                op = in_hblank ? OP_HBL_END : OP_HBL_START;
                in_hblank = !in_hblank;
            end else begin
                op = in_vblank ? OP_VBL_END : OP_VBL_START;
                in_vblank = !in_vblank;
            end
        end else begin
            op = OP_NONE;
        end
        send_beat(op, idx, sel, data);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset target, hold present on timer 0 and absent on timer 3, unused code
    task automatic test_register_access();
        send_beat(OP_READ,  2'd2, REG_TARGET, 16'h0000);
        send_beat(OP_WRITE, 2'd0, REG_HOLD,   16'hffff);
        send_beat(OP_READ,  2'd0, REG_HOLD,   16'h0000);
        send_beat(OP_WRITE, 2'd3, REG_HOLD,   16'hffff);
        send_beat(OP_READ,  2'd3, REG_HOLD,   16'h0000);
        send_beat(OP_NONE,  2'd3, REG_HOLD,   16'hffff);
    endtask

    // target hit then wrap at the top, flag clearing, zero target with zero return
    task automatic test_target_and_overflow();
        send_beat(OP_WRITE, 2'd0, REG_MODE,
                  mode_value(CLK_DIV2, GM_PAUSE, M_COUNT | M_TIRQ | M_OIRQ));
        send_beat(OP_WRITE, 2'd0, REG_COUNT, 16'hffff);
        send_beat(OP_TICK,  2'd0, REG_COUNT, 16'h0000);
        send_beat(OP_TICK,  2'd0, REG_COUNT, 16'h0000);
        send_beat(OP_READ,  2'd0, REG_MODE,  16'h0000);
        send_beat(OP_WRITE, 2'd0, REG_MODE,
                  mode_value(CLK_DIV32, GM_PAUSE,
                             M_TFLAG | M_OFLAG | M_COUNT | M_TIRQ | M_ZRET));
        // target write at or below count disarms, count write re-arms
        send_beat(OP_WRITE, 2'd0, REG_TARGET, 16'h0000);
        send_beat(OP_WRITE, 2'd0, REG_COUNT,  16'h0000);
        send_beat(OP_TICK,  2'd0, REG_COUNT,  16'h0000);
        send_beat(OP_READ,  2'd0, REG_COUNT,  16'h0000);
    endtask

    // hblank clock with hblank gate, vblank restart on both edges, hblank pause
    task automatic test_gate_modes();
        send_beat(OP_WRITE, 2'd2, REG_MODE,
                  mode_value(CLK_HBLANK, GM_PAUSE, M_GATE | M_COUNT | M_OIRQ));
        send_beat(OP_WRITE, 2'd3, REG_MODE,
                  mode_value(CLK_DIV2, GM_BOTH, M_GATE | M_VSRC | M_COUNT));
        send_beat(OP_WRITE, 2'd1, REG_MODE,
                  mode_value(CLK_DIV2, GM_PAUSE, M_GATE));
        send_beat(OP_HBL_START, 2'd0, REG_COUNT, 16'h0000);
        send_beat(OP_HBL_END,   2'd0, REG_COUNT, 16'h0000);
        send_beat(OP_VBL_START, 2'd0, REG_COUNT, 16'h0000);
        send_beat(OP_VBL_END,   2'd0, REG_COUNT, 16'h0000);
        send_beat(OP_READ,      2'd1, REG_MODE,  16'h0000);
        send_beat(OP_READ,      2'd2, REG_COUNT, 16'h0000);
    endtask

    task automatic test_random_registers();
        repeat (500) send_random_beat(1'b0);
    endtask

    // well-formed blank sequences with gated and hblank-clocked timers
    task automatic test_random_sync_sequences();
        repeat (500) send_random_beat(1'b1);
    endtask

    // closing stretch at full rate on both sides
    task automatic test_random_back_to_back();
        idling_on = 1'b0;
        repeat (200) send_random_beat($urandom_range(0, 1));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_target_and_overflow();
        test_gate_modes();
        test_random_registers();
        test_random_sync_sequences();
        test_random_back_to_back();

        s_tvalid <= 1'b0;
        // the watchdog catches replies that never arrive
        while (awaited_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side ready, held low in random bursts while idling is on
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // each result beat against the oldest predicted reply
    always @(posedge clk) begin : reply_check
        t_timer_reply         want;
        logic [DATA_BITS-1:0] got_data;
        logic [IRQ_BITS-1:0]  got_irq;
        if (rst_n && m_tvalid && m_tready) begin
            got_data = m_tdata[DATA_BITS-1:0];
            got_irq  = m_tdata[DATA_BITS +: IRQ_BITS];
            if (awaited_replies.size() == 0) begin
                $error("unexpected result beat: tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (got_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h", want.read_data, got_data);
                    fail_count++;
                end
                if (got_irq !== want.irq_raised) begin
                    $error("irq_raised: expected %h, got %h", want.irq_raised, got_irq);
                    fail_count++;
                end
            end
        end
    end

    // ends the run when no beat has moved on either side for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
